### rtl/core/ngga_pkg.sv
// shared types, constants and helper functions for the gga sentence parser
`default_nettype none

package ngga_pkg;

    // header text length and byte codes
    localparam int unsigned HdrLen = 6;
    localparam logic [7:0] ChrStar  = 8'h2A;
    localparam logic [7:0] ChrComma = 8'h2C;
    localparam logic [7:0] ChrZero  = 8'h30;
    localparam logic [7:0] ChrNine  = 8'h39;
    localparam logic [7:0] ChrUpA   = 8'h41;
    localparam logic [6:0] MaxHours = 7'd23;
    localparam logic [6:0] MaxMinSec = 7'd59;
    localparam logic [2:0] TimeDigits = 3'd6;

    // input item
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_sentence;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [3:0] field_number;
        logic [7:0] char_out;
        logic       char_valid;
        logic       field_end;
        logic       sentence_done;
        logic       header_ok;
        logic       checksum_present;
        logic       checksum_match;
        logic       time_valid;
        logic [6:0] time_hours;
        logic [6:0] time_minutes;
        logic [6:0] time_seconds;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0]        chr;
        logic              last;
        logic              is_star;
        logic              is_comma;
        logic              is_digit;
        logic [HdrLen-1:0] hdr_hit;
    } t_cls_item;

    // expected header byte at a position
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = 8'h24;
            3'd1:    r = 8'h47;
            3'd2:    r = 8'h50;
            3'd3:    r = 8'h47;
            3'd4:    r = 8'h47;
            3'd5:    r = 8'h41;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // uppercase hex digit for one nibble
    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = ChrZero + {4'b0, nib};
        end else begin
            r = ChrUpA + {4'b0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ngga_front.sv
// front end: accepts input bytes and classifies them
`default_nettype none

module ngga_front (
    input  wire ngga_pkg::t_in_item  i_item,
    output ngga_pkg::t_cls_item      o_cls
);
    import ngga_pkg::*;

    // per-byte classification
    always_comb begin
        o_cls.chr      = i_item.char_in;
        o_cls.last     = i_item.end_of_sentence;
        o_cls.is_star  = (i_item.char_in == ChrStar);
        o_cls.is_comma = (i_item.char_in == ChrComma);
        o_cls.is_digit = (i_item.char_in >= ChrZero) && (i_item.char_in <= ChrNine);
        for (int k = 0; k < HdrLen; k++) begin
            o_cls.hdr_hit[k] = (i_item.char_in == hdr_char(3'(k)));
        end
    end

endmodule

`default_nettype wire

### rtl/core/ngga_queue.sv
// two-entry queue between the front and back ends
`default_nettype none

module ngga_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  wire ngga_pkg::t_cls_item i_data,
    input  wire                      i_pop,
    output ngga_pkg::t_cls_item      o_data,
    output logic                     o_empty,
    output logic                     o_full
);
    import ngga_pkg::*;

    t_cls_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

`default_nettype wire

### rtl/core/ngga_back.sv
// back end: sentence state, checks and registered result
`default_nettype none

module ngga_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_go,
    input  wire ngga_pkg::t_cls_item i_cls,
    input  wire                      i_take,
    output logic                     o_valid,
    output ngga_pkg::t_out_item      o_item
);
    import ngga_pkg::*;

    logic [2:0]  r_byte_pos, n_byte_pos;
    logic        r_prefix_ok, n_prefix_ok;
    logic [7:0]  r_xor, n_xor;
    logic        r_past_star, n_past_star;
    logic [1:0]  r_rcv_cnt, n_rcv_cnt;
    logic [15:0] r_rcv_chars, n_rcv_chars;
    logic [3:0]  r_field, n_field;
    logic [2:0]  r_tdig, n_tdig;
    logic [6:0]  r_hours, n_hours;
    logic [6:0]  r_mins, n_mins;
    logic [6:0]  r_secs, n_secs;
    logic        r_tbad, n_tbad;
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        hdr;
    logic        in_range;
    logic [6:0]  acc;
    logic [6:0]  acc_next;
    logic [15:0] want;

    // select which time store the current digit feeds
    always_comb begin
        if (r_tdig < 3'd2) begin
            acc = r_hours;
        end else if (r_tdig < 3'd4) begin
            acc = r_mins;
        end else begin
            acc = r_secs;
        end
        acc_next = 7'({acc, 3'b000} + {acc, 1'b0} + {3'b000, i_cls.chr[3:0]});
    end

    // next sentence state and result for this byte
    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_prefix_ok = r_prefix_ok;
        n_xor       = r_xor;
        n_past_star = r_past_star;
        n_rcv_cnt   = r_rcv_cnt;
        n_rcv_chars = r_rcv_chars;
        n_field     = r_field;
        n_tdig      = r_tdig;
        n_hours     = r_hours;
        n_mins      = r_mins;
        n_secs      = r_secs;
        n_tbad      = r_tbad;
        n_out       = '0;

        in_range = (r_field >= 4'd1) && (r_field <= 4'd14);

        // header compare
        if (r_byte_pos < 3'(HdrLen) && !i_cls.hdr_hit[r_byte_pos[2:0]]) begin
            n_prefix_ok = 1'b0;
        end
        if (r_byte_pos != 3'd7) begin
            n_byte_pos = r_byte_pos + 3'd1;
        end
        hdr = n_prefix_ok && (r_byte_pos >= 3'(HdrLen - 1));

        // field body, separator or checksum text
        if (!r_past_star) begin
            if (i_cls.is_star) begin
                n_past_star     = 1'b1;
                n_out.field_end = hdr && in_range;
            end else begin
                if (r_byte_pos != 3'd0) begin
                    n_xor = r_xor ^ i_cls.chr;
                end
                if (i_cls.is_comma) begin
                    n_out.field_end = hdr && in_range;
                    if (r_field != 4'd15) begin
                        n_field = r_field + 4'd1;
                    end
                end else begin
                    n_out.char_valid = hdr && in_range;
                    // time digits of field one
                    if (r_field == 4'd1 && !r_tbad && r_tdig < TimeDigits) begin
                        if (!i_cls.is_digit) begin
                            n_tbad = 1'b1;
                        end else begin
                            if (r_tdig < 3'd2) begin
                                n_hours = acc_next;
                            end else if (r_tdig < 3'd4) begin
                                n_mins = acc_next;
                            end else begin
                                n_secs = acc_next;
                            end
                            n_tdig = r_tdig + 3'd1;
                        end
                    end
                end
            end
        end else if (!i_cls.is_star) begin
            if (r_rcv_cnt == 2'd0) begin
                n_rcv_chars = {i_cls.chr, 8'h00};
            end else if (r_rcv_cnt == 2'd1) begin
                n_rcv_chars = {r_rcv_chars[15:8], i_cls.chr};
            end
            if (r_rcv_cnt != 2'd3) begin
                n_rcv_cnt = r_rcv_cnt + 2'd1;
            end
        end

        want = {hex_upper(n_xor[7:4]), hex_upper(n_xor[3:0])};

        n_out.field_number  = r_field;
        n_out.char_out      = i_cls.chr;
        n_out.sentence_done = i_cls.last;

        // end-of-sentence status
        if (i_cls.last) begin
            n_out.header_ok        = hdr;
            n_out.checksum_present = hdr && (n_rcv_cnt != 2'd0);
            n_out.checksum_match   = hdr && (n_rcv_cnt == 2'd2) && (n_rcv_chars == want);
            n_out.time_valid       = hdr && !n_tbad && (n_tdig == TimeDigits) &&
                                     (n_hours <= MaxHours) && (n_mins <= MaxMinSec) &&
                                     (n_secs <= MaxMinSec);
            n_out.time_hours       = n_hours;
            n_out.time_minutes     = n_mins;
            n_out.time_seconds     = n_secs;
        end
    end

    // sentence state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_cls.last)) begin
            r_byte_pos  <= 3'd0;
            r_prefix_ok <= 1'b1;
            r_xor       <= 8'h00;
            r_past_star <= 1'b0;
            r_rcv_cnt   <= 2'd0;
            r_rcv_chars <= 16'h0000;
            r_field     <= 4'd0;
            r_tdig      <= 3'd0;
            r_hours     <= 7'd0;
            r_mins      <= 7'd0;
            r_secs      <= 7'd0;
            r_tbad      <= 1'b0;
        end else if (i_go) begin
            r_byte_pos  <= n_byte_pos;
            r_prefix_ok <= n_prefix_ok;
            r_xor       <= n_xor;
            r_past_star <= n_past_star;
            r_rcv_cnt   <= n_rcv_cnt;
            r_rcv_chars <= n_rcv_chars;
            r_field     <= n_field;
            r_tdig      <= n_tdig;
            r_hours     <= n_hours;
            r_mins      <= n_mins;
            r_secs      <= n_secs;
            r_tbad      <= n_tbad;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_go) begin
            r_out_valid <= 1'b1;
        end else if (i_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

### rtl/core/nmea_gga_sentence_parser_unit.sv
// top level of the gga sentence parser: front end, queue and back end
`default_nettype none

// Parses an NMEA GGA sentence fed one byte per item, the last byte flagged by
// end_of_sentence. Every input item yields exactly one result item carrying the
// byte, its comma field number and content/field-end tags; the result for the
// last byte also carries header, checksum and time status. One item per cycle
// is sustained while the output is not stalled: a byte passes the classifying
// front end, waits in a two-entry queue and is retired by the back end into
// the output register. The input stalls only while the queue holds two items.
// All sentence state returns to its reset values after the last byte.
module nmea_gga_sentence_parser_unit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire ngga_pkg::t_in_item  i_in_item,
    output logic                     o_valid,
    input  wire                      i_stall,
    output ngga_pkg::t_out_item      o_out_item
);
    import ngga_pkg::*;

    t_cls_item cls_in;
    t_cls_item cls_out;
    logic      q_empty;
    logic      q_full;
    logic      push;
    logic      pop;
    logic      out_valid;

    // handshake glue
    assign push    = i_valid && !q_full;
    assign pop     = !q_empty && (!out_valid || !i_stall);
    assign o_stall = q_full;
    assign o_valid = out_valid;

    // classify incoming bytes
    ngga_front u_front (
        .i_item (i_in_item),
        .o_cls  (cls_in)
    );

    // decoupling queue
    ngga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .i_pop   (pop),
        .o_data  (cls_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // sentence state and result register
    ngga_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (pop),
        .i_cls   (cls_out),
        .i_take  (!i_stall),
        .o_valid (out_valid),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire
